// ===== design/miller_rabin_witness_test_top_assert.svh =====
`ifndef MILLER_RABIN_WITNESS_TEST_TOP_ASSERT_SVH
`define MILLER_RABIN_WITNESS_TEST_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define MRWT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MRWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mrwt_pkg.sv =====
package mrwt_pkg;

  localparam int WIDTH_DEFAULT = 64;
  localparam int OUT_TDATA_W   = 8;

  typedef enum logic [1:0] {
    RSN_BELOW_TWO = 2'd0,
    RSN_EVEN      = 2'd1,
    RSN_WITNESS   = 2'd2,
    RSN_PASS      = 2'd3
  } reason_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_RED,
    DP_TZ,
    DP_MUL_ACC_SQ,
    DP_MUL_SQ_SQ,
    DP_MUL_CUR,
    DP_MUL_STEP,
    DP_WR_ACC,
    DP_WR_SQ,
    DP_WR_CUR,
    DP_PREV_INIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_eq2;
    logic n_odd;
    logic red_done;
    logic e_lsb;
    logic e_zero;
    logic s_zero;
    logic mul_zero;
    logic acc_one;
    logic hit;
  } dp_status_t;

endpackage

// ===== design/mrwt_modmul.sv =====
module mrwt_modmul
  import mrwt_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             start,
  input  logic             step,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic [WIDTH-1:0] prod,
  output logic             zero
);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] addend;
  logic [WIDTH-1:0] mult;

  // (x + y) mod m for x, y < m
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] md);
    logic [WIDTH:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum >= {1'b0, md}) begin
      sum = sum - {1'b0, md};
    end
    return sum[WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      addend <= a;
      mult   <= b;
    end else if (step && (mult != '0)) begin
      if (mult[0]) begin
        acc <= add_mod(acc, addend, m);
      end
      addend <= add_mod(addend, addend, m);
      mult   <= mult >> 1;
    end
  end

  assign prod = acc;
  assign zero = (mult == '0);

endmodule

// ===== design/mrwt_dp.sv =====
module mrwt_dp
  import mrwt_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic             clk,
  input  dp_cmd_t          cmd,
  input  logic [WIDTH-1:0] candidate,
  input  logic [WIDTH-1:0] base,
  output dp_status_t       status
);

  localparam int CW = $clog2(WIDTH + 1);
  localparam int SW = $clog2(WIDTH);

  logic [WIDTH-1:0] n;
  logic [WIDTH-1:0] nm1;
  logic [WIDTH-1:0] bsh;
  logic [WIDTH-1:0] red;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] e;
  logic [SW-1:0]    s_cnt;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] sq;
  logic [WIDTH-1:0] prev;

  logic [WIDTH:0]   red2;
  logic [WIDTH:0]   red_next;

  logic             mm_start;
  logic             mm_step;
  logic [WIDTH-1:0] mm_a;
  logic [WIDTH-1:0] mm_b;
  logic [WIDTH-1:0] mm_prod;
  logic             mm_zero;

  // one remainder bit per cycle, msb of base first
  always_comb begin
    red2     = {red, bsh[WIDTH-1]};
    red_next = red2;
    if (red2 >= {1'b0, n}) begin
      red_next = red2 - {1'b0, n};
    end
  end

  always_comb begin
    mm_start = 1'b0;
    mm_a     = sq;
    mm_b     = sq;
    case (cmd.op)
      DP_MUL_ACC_SQ: begin
        mm_start = 1'b1;
        mm_a     = acc;
      end
      DP_MUL_SQ_SQ, DP_WR_ACC: begin
        mm_start = 1'b1;
      end
      DP_MUL_CUR: begin
        mm_start = 1'b1;
        mm_a     = acc;
        mm_b     = acc;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  assign mm_step = (cmd.op == DP_MUL_STEP);

  mrwt_modmul #(
    .WIDTH (WIDTH)
  ) u_modmul (
    .clk   (clk),
    .start (mm_start),
    .step  (mm_step),
    .a     (mm_a),
    .b     (mm_b),
    .m     (n),
    .prod  (mm_prod),
    .zero  (mm_zero)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        n     <= candidate;
        nm1   <= candidate - WIDTH'(1);
        e     <= candidate - WIDTH'(1);
        bsh   <= base;
        red   <= '0;
        cnt   <= CW'(WIDTH);
        s_cnt <= '0;
        acc   <= WIDTH'(1);
      end
      DP_RED: begin
        red <= red_next[WIDTH-1:0];
        bsh <= bsh << 1;
        cnt <= cnt - CW'(1);
      end
      DP_TZ: begin
        sq <= red;
        if (!e[0]) begin
          e     <= e >> 1;
          s_cnt <= s_cnt + SW'(1);
        end
      end
      DP_MUL_CUR: begin
        s_cnt <= s_cnt - SW'(1);
      end
      DP_WR_ACC: begin
        acc <= mm_prod;
      end
      DP_WR_SQ: begin
        sq <= mm_prod;
        e  <= e >> 1;
      end
      DP_WR_CUR: begin
        acc  <= mm_prod;
        prev <= mm_prod;
      end
      DP_PREV_INIT: begin
        prev <= acc;
      end
      default: begin
        n <= n;
      end
    endcase
  end

  always_comb begin
    status.n_lt2    = (n < WIDTH'(2));
    status.n_eq2    = (n == WIDTH'(2));
    status.n_odd    = n[0];
    status.red_done = (cnt == '0);
    status.e_lsb    = e[0];
    status.e_zero   = (e == '0);
    status.s_zero   = (s_cnt == '0);
    status.mul_zero = mm_zero;
    status.acc_one  = (acc == WIDTH'(1));
    status.hit      = (mm_prod == WIDTH'(1)) && (prev != WIDTH'(1)) && (prev != nm1);
  end

endmodule

// ===== design/mrwt_ctrl.sv =====
module mrwt_ctrl
  import mrwt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output reason_t    out_reason,
  output dp_cmd_t    cmd,
  input  dp_status_t st
);

  `include "miller_rabin_witness_test_top_assert.svh"

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_CLASS   = 10'b0000000010,
    ST_RED     = 10'b0000000100,
    ST_TZ      = 10'b0000001000,
    ST_EXP_CHK = 10'b0000010000,
    ST_MUL_A   = 10'b0000100000,
    ST_MUL_B   = 10'b0001000000,
    ST_SQR_CHK = 10'b0010000000,
    ST_MUL_C   = 10'b0100000000,
    ST_DONE    = 10'b1000000000
  } state_t;

  state_t  state;
  state_t  state_next;
  reason_t verdict;
  reason_t verdict_next;
  logic    load_out;

  assign in_ready = (state == ST_IDLE);
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next   = state;
    verdict_next = verdict;
    cmd.op       = DP_NOP;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (st.n_lt2) begin
          verdict_next = RSN_BELOW_TWO;
          state_next   = ST_DONE;
        end else if (st.n_eq2) begin
          verdict_next = RSN_PASS;
          state_next   = ST_DONE;
        end else if (!st.n_odd) begin
          verdict_next = RSN_EVEN;
          state_next   = ST_DONE;
        end else begin
          state_next = ST_RED;
        end
      end
      ST_RED: begin
        if (st.red_done) begin
          state_next = ST_TZ;
        end else begin
          cmd.op = DP_RED;
        end
      end
      ST_TZ: begin
        cmd.op = DP_TZ;
        if (st.e_lsb) begin
          state_next = ST_EXP_CHK;
        end
      end
      ST_EXP_CHK: begin
        if (st.e_zero) begin
          cmd.op     = DP_PREV_INIT;
          state_next = ST_SQR_CHK;
        end else if (st.e_lsb) begin
          cmd.op     = DP_MUL_ACC_SQ;
          state_next = ST_MUL_A;
        end else begin
          cmd.op     = DP_MUL_SQ_SQ;
          state_next = ST_MUL_B;
        end
      end
      ST_MUL_A: begin
        if (st.mul_zero) begin
          cmd.op     = DP_WR_ACC;
          state_next = ST_MUL_B;
        end else begin
          cmd.op = DP_MUL_STEP;
        end
      end
      ST_MUL_B: begin
        if (st.mul_zero) begin
          cmd.op     = DP_WR_SQ;
          state_next = ST_EXP_CHK;
        end else begin
          cmd.op = DP_MUL_STEP;
        end
      end
      ST_SQR_CHK: begin
        if (st.s_zero) begin
          verdict_next = st.acc_one ? RSN_PASS : RSN_WITNESS;
          state_next   = ST_DONE;
        end else begin
          cmd.op     = DP_MUL_CUR;
          state_next = ST_MUL_C;
        end
      end
      ST_MUL_C: begin
        if (st.mul_zero) begin
          cmd.op = DP_WR_CUR;
          if (st.hit) begin
            verdict_next = RSN_WITNESS;
            state_next   = ST_DONE;
          end else begin
            state_next = ST_SQR_CHK;
          end
        end else begin
          cmd.op = DP_MUL_STEP;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    verdict <= verdict_next;
    if (load_out) begin
      out_reason <= verdict;
    end
  end

  `MRWT_ASSERT_NEXT(a_accept_to_class, in_valid && in_ready, state == ST_CLASS,
                    "accepted word did not start classification")
  `MRWT_ASSERT_NEXT(a_done_loads_out, load_out, out_valid && (out_reason == $past(verdict)),
                    "verdict not moved to output register")
  `MRWT_ASSERT_NEXT(a_final_check, (state == ST_SQR_CHK) && st.s_zero,
                    (verdict == ($past(st.acc_one) ? RSN_PASS : RSN_WITNESS)),
                    "final value check gave wrong verdict")
  `MRWT_ASSERT_NOW(a_mul_write_done, (cmd.op == DP_WR_ACC) || (cmd.op == DP_WR_SQ)
                   || (cmd.op == DP_WR_CUR), st.mul_zero,
                   "product written before multiplier finished")

endmodule

// ===== design/miller_rabin_witness_test_top.sv =====
// Miller-Rabin witness test for one candidate and one base per input word. Candidates below
// two and even candidates other than two are rejected at once; two passes. For odd candidates
// the base is reduced modulo the candidate one bit per cycle, the trailing zeros of
// candidate-1 are stripped one per cycle, then the base is raised to the odd part by
// square-and-multiply and the result squared once per stripped zero, stopping early at a
// nontrivial square root of one. Every modular product runs on one shift-and-add multiplier
// that retires one multiplier bit per cycle. One item is worked on at a time; the next word
// is taken as soon as the verdict sits in the output register, even if that has not been
// taken yet.
module miller_rabin_witness_test_top
  import mrwt_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // candidate, base
  input  logic [((2*WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // probable_prime, verdict_reason
  output logic [OUT_TDATA_W-1:0]               m_tdata
);

  dp_cmd_t    cmd;
  dp_status_t st;
  reason_t    reason;

  mrwt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_reason (reason),
    .cmd        (cmd),
    .st         (st)
  );

  mrwt_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .candidate (s_tdata[WIDTH-1:0]),
    .base      (s_tdata[2*WIDTH-1:WIDTH]),
    .status    (st)
  );

  assign m_tdata = {{(OUT_TDATA_W-3){1'b0}}, reason, (reason == RSN_PASS)};

endmodule

// ===== dv/miller_rabin_witness_test_top_tb.sv =====
`timescale 1ns / 1ps

module miller_rabin_witness_test_top_tb
  import mrwt_pkg::*;
();

  localparam int W = WIDTH_DEFAULT;
  localparam int DATA_W = ((2 * W + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 60000;
  localparam int HOLD_CYCLES = 3000;
  localparam int TAIL_CYCLES = 20;

  // packs as {base, cand}, so cand lands in the low bits of tdata
  typedef struct packed {
    logic [W-1:0] base;
    logic [W-1:0] cand;
  } word_t;

  typedef struct packed {
    logic [W-1:0] cand;
    logic [W-1:0] base;
    logic         probable;
    reason_t      reason;
  } verdict_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  word_t    pending_words[$];
  verdict_t verdict_q[$];
  verdict_t head;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  int hold_count = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int words_sent = 0;
  int verdicts_seen = 0;
  int seen_by_reason[4] = '{0, 0, 0, 0};

  miller_rabin_witness_test_top #(
    .WIDTH(W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [W-1:0] modmul(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] m);
    logic [2*W-1:0] prod;
    logic [2*W-1:0] rem;
    prod = {{W{1'b0}}, x} * {{W{1'b0}}, y};
    rem = prod % {{W{1'b0}}, m};
    return rem[W-1:0];
  endfunction

  function automatic logic [W-1:0] modpow(input logic [W-1:0] g, input logic [W-1:0] e,
                                          input logic [W-1:0] m);
    logic [W-1:0] acc;
    logic [W-1:0] sq;
    logic [W-1:0] ex;
    acc = 1;
    sq = g % m;
    ex = e;
    while (ex != 0) begin
      if (ex[0]) acc = modmul(acc, sq, m);
      sq = modmul(sq, sq, m);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic verdict_t predict_verdict(input logic [W-1:0] cand,
                                               input logic [W-1:0] base);
    verdict_t v;
    logic [W-1:0] d;
    logic [W-1:0] cur;
    logic [W-1:0] prev;
    bit witness;
    int s;
    int k;
    v.cand = cand;
    v.base = base;
    if (cand < 2) begin
      v.probable = 1'b0;
      v.reason = RSN_BELOW_TWO;
    end else if (cand == 2) begin
      v.probable = 1'b1;
      v.reason = RSN_PASS;
    end else if (!cand[0]) begin
      v.probable = 1'b0;
      v.reason = RSN_EVEN;
    end else begin
      d = cand - 1;
      s = 0;
      while (!d[0]) begin
        d = d >> 1;
        s++;
      end
      cur = modpow(base, d, cand);
      prev = cur;
      witness = 1'b0;
      // a nontrivial square root of one proves the candidate composite
      for (k = 0; k < s; k++) begin
        if (!witness) begin
          cur = modmul(cur, cur, cand);
          if (cur == 1 && prev != 1 && prev != cand - 1) witness = 1'b1;
          prev = cur;
        end
      end
      if (!witness) witness = (cur != 1);
      v.probable = !witness;
      v.reason = witness ? RSN_WITNESS : RSN_PASS;
    end
    return v;
  endfunction

  function automatic logic [W-1:0] rand_wide();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [W-1:0] pick_base(input logic [W-1:0] n);
    case ($urandom_range(0, 9))
      0: return 1;
      1: return n - 1;
      2: return '0;
      3: return n * $urandom_range(1, 1000);
      4: return $urandom_range(2, 5);
      default: return rand_wide();
    endcase
  endfunction

  function automatic word_t random_word(input bit cheap);
    logic [W-1:0] n;
    int kind;
    kind = cheap ? $urandom_range(0, 19) : $urandom_range(0, 99);
    if (kind < 5) begin
      n = $urandom_range(0, 1);
    end else if (kind < 7) begin
      n = 2;
    end else if (kind < 20) begin
      if ($urandom_range(0, 1)) begin
        n = rand_wide();
        n[0] = 1'b0;
      end else begin
        n = $urandom_range(2, 500) * 2;
      end
    end else if (kind < 45) begin
      case ($urandom_range(0, 13))
        0: n = 3;
        1: n = 5;
        2: n = 7;
        3: n = 11;
        4: n = 13;
        5: n = 97;
        6: n = 101;
        7: n = 257;
        8: n = 7919;
        9: n = 65521;
        10: n = 65537;
        11: n = 1000003;
        12: n = 64'd2147483647;
        default: n = 64'd4294967291;
      endcase
    end else if (kind < 65) begin
      n = $urandom_range(3, 65535) | 1;
    end else if (kind < 73) begin
      // carmichael numbers and strong pseudoprimes
      case ($urandom_range(0, 10))
        0: n = 561;
        1: n = 1105;
        2: n = 1729;
        3: n = 2047;
        4: n = 2465;
        5: n = 2821;
        6: n = 3277;
        7: n = 4033;
        8: n = 8911;
        9: n = 64'd25326001;
        default: n = 64'd3215031751;
      endcase
    end else if (kind < 80) begin
      n = rand_wide();
      n[0] = 1'b1;
    end else begin
      n = {$urandom} | 1;
    end
    return '{base: pick_base(n), cand: n};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic add_word(input logic [W-1:0] cand, input logic [W-1:0] base);
    pending_words.push_back('{base: base, cand: cand});
  endtask

  task automatic drain_results();
    while (pending_words.size() != 0 || s_tvalid || verdict_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) pending_words.push_back(random_word(1'b0));
    drain_results();
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        verdict_q.push_back(predict_verdict(s_tdata[W-1:0], s_tdata[2*W-1:W]));
        words_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          s_tdata <= pending_words.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off
  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
      else hold_count <= hold_count + 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(hold_arm && !hold_done) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // verdict checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict word 0x%0h with none pending", m_tdata));
      end else begin
        head = verdict_q.pop_front();
        seen_by_reason[head.reason]++;
        if (m_tdata[0] !== head.probable)
          report_mismatch($sformatf("n=%0d a=%0d probable_prime %b, want %b",
                                    head.cand, head.base, m_tdata[0], head.probable));
        if (m_tdata[2:1] !== head.reason)
          report_mismatch($sformatf("n=%0d a=%0d verdict_reason %0d, want %0d",
                                    head.cand, head.base, m_tdata[2:1], head.reason));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without a word, %0d verdicts pending",
               IDLE_LIMIT, verdict_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_word(64'd0, 64'd0);
    add_word(64'd1, {W{1'b1}});
    add_word(64'd2, 64'd5);
    add_word(64'd2, 64'd0);
    add_word(64'd4, 64'd3);
    add_word({{(W-1){1'b1}}, 1'b0}, rand_wide());
    add_word(64'd3, 64'd2);
    add_word(64'd3, 64'd0);
    add_word(64'd7, 64'd14);
    add_word(64'd9, 64'd8);
    add_word(64'd9, 64'd1);
    add_word(64'd561, 64'd2);
    add_word(64'd2047, 64'd2);
    add_word(64'd2047, 64'd3);
    add_word(64'd15, 64'd4);
    add_word(64'hFFFF_FFFF_FFFF_FFC5, {W{1'b1}});
    add_word(64'h1FFF_FFFF_FFFF_FFFF, 64'd3);
    add_word({W{1'b1}}, 64'd2);
    add_word(64'd3215031751, 64'd2);
    add_word(64'd65537, 64'd196611);
    add_word(64'd97, 64'hF000_0000_0000_0001);
    drain_results();

    run_phase(0, 0, 15);
    run_phase(84, 0, 15);
    run_phase(0, 84, 15);
    run_phase(26, 26, 15);

    // receiver held off while cheap words keep coming, so the input backs up
    @(negedge clk);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_arm = 1'b1;
    repeat (12) pending_words.push_back(random_word(1'b1));
    while (!hold_done) @(negedge clk);
    drain_results();

    run_phase(0, 0, 8);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));

    $display("%0d verdicts for %0d words: %0d below two, %0d even, %0d witnessed, %0d passed",
             verdicts_seen, words_sent, seen_by_reason[RSN_BELOW_TWO],
             seen_by_reason[RSN_EVEN], seen_by_reason[RSN_WITNESS], seen_by_reason[RSN_PASS]);
    $display("pacing: free flow, sparse input, stalled output, mixed, one long output hold-off");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
